// File: src/lle_pkg.sv
// Package for the linked list engine: command and status codes,
// state encoding and the input and result beat structs. No dependencies.
package lle_pkg;

  typedef enum logic [2:0] {
    CMD_INS_HEAD   = 3'd0,
    CMD_INS_TAIL   = 3'd1,
    CMD_INS_AFTER  = 3'd2,
    CMD_DEL_MATCH  = 3'd3,
    CMD_DEL_HEAD   = 3'd4,
    CMD_DEL_TAIL   = 3'd5,
    CMD_SEARCH     = 3'd6,
    CMD_PREFIX_SUM = 3'd7
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PREP,
    S_PSUM,
    S_LINK2
  } state_t;

  typedef struct packed {
    cmd_e_t             command;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } in_beat_t;

  typedef struct packed {
    status_e_t          status;
    logic signed [31:0] data;
    logic        [4:0]  position;
    logic               last;
  } out_beat_t;

  localparam int unsigned MAX_RESULTS = 32;

endpackage

// File: src/linked_list_engine.sv
// Linked list engine top level: command sequencer, node walk and result register.
// Depends on lle_pkg and lle_ram (value store and link store).
//
// A command is taken when start is high and busy is low. Insert at head, insert at
// tail into an empty list, and any command that fails at once on a full or empty list
// finish without a walk. Commands that walk the chain advance one node per clock,
// set by the registered read of the link store: search, delete and insert-after walk
// until the match or the end; insert-after then writes a second link, and prefix sum
// walks twice (find, then sum). Each result shows on out_beat for exactly one cycle
// with out_valid high and cannot be stalled; the final result of a command has
// last set. Nodes in use are tracked in flip-flops, so no clearing pass is needed.
module linked_list_engine #(
  parameter int LIST_CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lle_pkg::in_beat_t in_beat,
  output logic              out_valid,
  output lle_pkg::out_beat_t out_beat
);

  import lle_pkg::*;

  localparam int SW = $clog2(LIST_CAPACITY);
  localparam int LW = $clog2(LIST_CAPACITY + 1);

  state_t                    state_r, state_nxt;
  cmd_e_t                    cmd_r, cmd_nxt;
  logic signed [31:0]        val_r, val_nxt;
  logic signed [31:0]        key_r, key_nxt;
  logic [SW-1:0]             cur_r, cur_nxt;
  logic [SW-1:0]             prev_r, prev_nxt;
  logic [SW-1:0]             new_r, new_nxt;
  logic [SW-1:0]             head_r, head_nxt;
  logic [LW-1:0]             pos_r, pos_nxt;
  logic [LW-1:0]             tgt_r, tgt_nxt;
  logic [LW-1:0]             len_r, len_nxt;
  logic [LIST_CAPACITY-1:0]  used_r, used_nxt;
  logic [31:0]               sum_r, sum_nxt;
  out_beat_t                 out_r, out_nxt;
  logic                      out_vld_r, out_vld_nxt;

  logic                      val_we, link_we;
  logic [SW-1:0]             val_waddr, link_waddr, raddr;
  logic [31:0]               val_wdata, rd_val;
  logic [SW-1:0]             link_wdata, rd_link, rd_link_ok;
  logic [SW-1:0]             free_slot;
  logic                      accept, full, empty, hit, at_end;
  logic signed [31:0]        match_val;
  logic [31:0]               pos_ext;

  lle_ram #(.WIDTH(32), .DEPTH(LIST_CAPACITY)) u_values (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(raddr), .rdata(rd_val)
  );

  lle_ram #(.WIDTH(SW), .DEPTH(LIST_CAPACITY)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(raddr), .rdata(rd_link)
  );

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign full       = (32'(len_r) >= LIST_CAPACITY);
  assign empty      = (len_r == '0);
  assign rd_link_ok = (32'(rd_link) < LIST_CAPACITY) ? rd_link : '0;
  assign raddr      = (state_r == S_WALK || state_r == S_PSUM) ? rd_link_ok : head_r;
  assign match_val  = (cmd_r == CMD_INS_AFTER) ? key_r : val_r;
  assign at_end     = (pos_r == len_r - LW'(1));
  assign pos_ext    = 32'(pos_r);
  assign out_valid  = out_vld_r;
  assign out_beat   = out_r;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = LIST_CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) free_slot = SW'(i);
    end
  end

  always_comb begin
    unique case (cmd_r)
      CMD_INS_TAIL, CMD_DEL_TAIL: hit = at_end;
      CMD_DEL_HEAD:               hit = (pos_r == '0);
      CMD_INS_HEAD:               hit = 1'b1;
      CMD_INS_AFTER, CMD_DEL_MATCH, CMD_SEARCH, CMD_PREFIX_SUM:
                                  hit = (rd_val == match_val);
      default:                    hit = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !(in_beat.command <= CMD_INS_AFTER && full)
            && !(in_beat.command >= CMD_INS_AFTER && empty)
            && in_beat.command != CMD_INS_HEAD
            && !(in_beat.command == CMD_INS_TAIL && empty)) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (hit) begin
          if (cmd_r == CMD_PREFIX_SUM)     state_nxt = S_PREP;
          else if (cmd_r == CMD_INS_AFTER) state_nxt = S_LINK2;
          else                             state_nxt = S_IDLE;
        end else if (at_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_PREP:  state_nxt = S_PSUM;
      S_PSUM:  if (pos_r == tgt_r) state_nxt = S_IDLE;
      S_LINK2: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, store writes and results
  always_comb begin
    cmd_nxt     = cmd_r;
    val_nxt     = val_r;
    key_nxt     = key_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    new_nxt     = new_r;
    head_nxt    = head_r;
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    len_nxt     = len_r;
    used_nxt    = used_r;
    sum_nxt     = sum_r;
    out_nxt     = out_r;
    out_vld_nxt = 1'b0;
    val_we      = 1'b0;
    val_waddr   = free_slot;
    val_wdata   = val_r;
    link_we     = 1'b0;
    link_waddr  = free_slot;
    link_wdata  = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt          = in_beat.command;
          val_nxt          = in_beat.value;
          key_nxt          = in_beat.key;
          cur_nxt          = head_r;
          prev_nxt         = head_r;
          pos_nxt          = '0;
          out_nxt.status   = ST_OK;
          out_nxt.data     = '0;
          out_nxt.position = '0;
          out_nxt.last     = 1'b1;
          if (in_beat.command <= CMD_INS_AFTER && full) begin
            out_nxt.status = ST_FULL;
            out_vld_nxt    = 1'b1;
          end else if (in_beat.command >= CMD_INS_AFTER && empty) begin
            out_nxt.status = ST_EMPTY;
            out_vld_nxt    = 1'b1;
          end else if (in_beat.command == CMD_INS_HEAD
                       || (in_beat.command == CMD_INS_TAIL && empty)) begin
            val_we               = 1'b1;
            val_wdata            = in_beat.value;
            link_we              = (in_beat.command == CMD_INS_HEAD);
            head_nxt             = free_slot;
            used_nxt[free_slot]  = 1'b1;
            len_nxt              = len_r + LW'(1);
            out_vld_nxt          = 1'b1;
          end
        end
      end
      S_WALK: begin
        out_nxt.status   = ST_OK;
        out_nxt.data     = '0;
        out_nxt.position = '0;
        out_nxt.last     = 1'b1;
        if (hit) begin
          unique case (cmd_r)
            CMD_INS_TAIL: begin
              val_we              = 1'b1;
              link_we             = 1'b1;
              link_waddr          = cur_r;
              link_wdata          = free_slot;
              used_nxt[free_slot] = 1'b1;
              len_nxt             = len_r + LW'(1);
              out_vld_nxt         = 1'b1;
            end
            CMD_INS_AFTER: begin
              val_we              = 1'b1;
              link_we             = 1'b1;
              link_wdata          = rd_link_ok;
              new_nxt             = free_slot;
              used_nxt[free_slot] = 1'b1;
              len_nxt             = len_r + LW'(1);
            end
            CMD_DEL_MATCH, CMD_DEL_HEAD, CMD_DEL_TAIL: begin
              if (pos_r == '0) begin
                head_nxt = rd_link_ok;
              end else begin
                link_we    = 1'b1;
                link_waddr = prev_r;
                link_wdata = rd_link_ok;
              end
              used_nxt[cur_r] = 1'b0;
              len_nxt         = len_r - LW'(1);
              out_vld_nxt     = 1'b1;
            end
            CMD_SEARCH: begin
              out_nxt.data     = rd_val;
              out_nxt.position = pos_ext[4:0];
              out_vld_nxt      = 1'b1;
            end
            CMD_PREFIX_SUM: begin
              tgt_nxt = pos_r;
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end else if (at_end) begin
          out_nxt.status = ST_NOT_FOUND;
          out_vld_nxt    = 1'b1;
        end else begin
          // advance one node
          prev_nxt = cur_r;
          cur_nxt  = rd_link_ok;
          pos_nxt  = pos_r + LW'(1);
        end
      end
      S_PREP: begin
        pos_nxt = '0;
        sum_nxt = '0;
      end
      S_PSUM: begin
        sum_nxt          = sum_r + rd_val;
        out_nxt.status   = ST_OK;
        out_nxt.data     = sum_r + rd_val;
        out_nxt.position = pos_ext[4:0];
        out_nxt.last     = (pos_r == tgt_r);
        // drop beats beyond the result limit, keep the final one
        out_vld_nxt      = (pos_r == tgt_r) || (pos_ext < MAX_RESULTS - 1);
        pos_nxt          = pos_r + LW'(1);
      end
      S_LINK2: begin
        link_we          = 1'b1;
        link_waddr       = cur_r;
        link_wdata       = new_r;
        out_nxt.status   = ST_OK;
        out_nxt.data     = '0;
        out_nxt.position = '0;
        out_nxt.last     = 1'b1;
        out_vld_nxt      = 1'b1;
      end
      default: begin
        out_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      len_r     <= '0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      len_r     <= len_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    val_r  <= val_nxt;
    key_r  <= key_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    new_r  <= new_nxt;
    pos_r  <= pos_nxt;
    tgt_r  <= tgt_nxt;
    sum_r  <= sum_nxt;
    out_r  <= out_nxt;
  end

  a_len_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == 32'(len_r))
    else $error("in-use map disagrees with list length");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= LIST_CAPACITY)
    else $error("list length beyond capacity");

  a_head_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_beat.command == CMD_INS_HEAD |=> out_valid && out_beat.last && !busy)
    else $error("insert at head did not finish in one cycle");

  a_idle_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy ##1 !busy |-> out_valid && out_beat.last)
    else $error("walk ended without a final result");

endmodule

// File: src/lle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench for linked_list_engine: drives list commands and checks every result
// beat against an in-bench model of the node store. Depends on lle_pkg and the RTL.
module tb_top;
  import lle_pkg::*;

  localparam int CAP = 32;

  class list_scoreboard;
    out_beat_t pending[$];
    int        mismatches;
    logic [31:0] vals[CAP];
    logic [4:0]  links[CAP];
    logic [CAP-1:0] used;
    logic [4:0]  head;
    int          length;

    function void clear();
      used = '0; head = '0; length = 0; mismatches = 0;
      pending.delete();
    endfunction

    function int count();
      return length;
    endfunction

    function void push(status_e_t st, logic [31:0] d, logic [4:0] p, logic l);
      out_beat_t b;
      b.status = st; b.data = d; b.position = p; b.last = l;
      pending.push_back(b);
    endfunction

    function logic [4:0] grab(logic [31:0] v);
      int s;
      s = 0;
      while (s < CAP && used[s]) s++;
      if (s >= CAP) s = 0;
      used[s] = 1'b1; vals[s] = v; length++;
      return s[4:0];
    endfunction

    // position of first match, or length if none; slots of match and its predecessor
    function int locate(logic [31:0] v, output logic [4:0] c, output logic [4:0] pr);
      int p;
      p = 0; c = head; pr = head;
      while (p < length) begin
        if (vals[c] == v) break;
        pr = c; c = links[c]; p++;
      end
      return p;
    endfunction

    function void unlink(int p, logic [4:0] c, logic [4:0] pr);
      if (p == 0) head = links[c];
      else links[pr] = links[c];
      used[c] = 1'b0; length--;
    endfunction

    function void note_command(in_beat_t b);
      logic [4:0] c, pr, s;
      logic [31:0] sum;
      int p, k;
      if (b.command inside {CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER} && length >= CAP) begin
        push(ST_FULL, '0, '0, 1'b1); return;
      end
      if (b.command >= CMD_INS_AFTER && length == 0) begin
        push(ST_EMPTY, '0, '0, 1'b1); return;
      end
      case (b.command)
        CMD_INS_HEAD: begin
          s = grab(b.value); links[s] = head; head = s;
        end
        CMD_INS_TAIL: begin
          if (length == 0) head = grab(b.value);
          else begin
            c = head;
            for (int i = 1; i < length; i++) c = links[c];
            s = grab(b.value); links[c] = s;
          end
        end
        CMD_INS_AFTER: begin
          p = locate(b.key, c, pr);
          if (p >= length) begin push(ST_NOT_FOUND, '0, '0, 1'b1); return; end
          s = grab(b.value); links[s] = links[c]; links[c] = s;
        end
        CMD_DEL_MATCH: begin
          p = locate(b.value, c, pr);
          if (p >= length) begin push(ST_NOT_FOUND, '0, '0, 1'b1); return; end
          unlink(p, c, pr);
        end
        CMD_DEL_HEAD: unlink(0, head, head);
        CMD_DEL_TAIL: begin
          c = head; pr = c;
          for (int i = 1; i < length; i++) begin pr = c; c = links[c]; end
          unlink(length - 1, c, pr);
        end
        CMD_SEARCH: begin
          p = locate(b.value, c, pr);
          if (p >= length) push(ST_NOT_FOUND, '0, '0, 1'b1);
          else push(ST_OK, vals[c], p[4:0], 1'b1);
          return;
        end
        default: begin
          p = locate(b.value, c, pr);
          if (p >= length) begin push(ST_NOT_FOUND, '0, '0, 1'b1); return; end
          sum = '0; k = 0; c = head;
          for (int i = 0; i < p; i++) begin
            sum += vals[c];
            if (k < MAX_RESULTS - 1) begin push(ST_OK, sum, i[4:0], 1'b0); k++; end
            c = links[c];
          end
          sum += vals[c];
          push(ST_OK, sum, p[4:0], 1'b1);
          return;
        end
      endcase
      push(ST_OK, '0, '0, 1'b1);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.data !== want.data ||
          got.position !== want.position || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid;
  in_beat_t  in_beat;
  out_beat_t out_beat;
  list_scoreboard sb;
  int send_idle;
  logic [31:0] pool[8];

  linked_list_engine #(.LIST_CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_beat);
  end

  // hold start until the beat is taken; idle at random first, else keep start high
  task automatic send(cmd_e_t c, logic [31:0] v, logic [31:0] k);
    in_beat_t b;
    b.command = c; b.value = v; b.key = k;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(b);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (sb.pending.size() != 0 && guard < 100000) begin @(posedge clk); guard++; end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(3);
      default: return pool[$urandom_range(7)];
    endcase
  endfunction

  task automatic random_phase(int n, int idle);
    cmd_e_t c;
    send_idle = idle;
    for (int i = 0; i < n; i++) begin
      // bias towards inserts while short, deletes while nearly full
      if (sb.count() < 6 && $urandom_range(1)) c = cmd_e_t'($urandom_range(2));
      else if (sb.count() > 28 && $urandom_range(1)) c = cmd_e_t'($urandom_range(5, 3));
      else c = cmd_e_t'($urandom_range(7));
      send(c, pick_value(), pick_value());
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 1'b0; start = 1'b0; in_beat = '0; send_idle = 0;
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    pool[0] = 32'h7fff_ffff; pool[1] = 32'h8000_0000; pool[2] = '0; pool[3] = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list cases
    for (int c = 2; c < 8; c++) send(cmd_e_t'(c), pool[0], pool[1]);
    send(CMD_INS_TAIL, pool[0], '0);
    send(CMD_INS_HEAD, pool[1], '0);
    send(CMD_INS_AFTER, pool[3], pool[1]);
    send(CMD_INS_AFTER, pool[2], 32'h1234_5678);
    send(CMD_PREFIX_SUM, pool[0], '0);
    send(CMD_PREFIX_SUM, 32'h5555_5555, '0);
    send(CMD_SEARCH, pool[3], '0);
    send(CMD_DEL_MATCH, 32'h0bad_0bad, '0);
    send(CMD_DEL_MATCH, pool[3], '0);
    send(CMD_DEL_TAIL, '0, '0);
    send(CMD_DEL_HEAD, '0, '0);
    send(CMD_DEL_HEAD, '0, '0);
    // fill to capacity, then full cases and a long prefix sum
    for (int i = 0; i < CAP; i++) send(CMD_INS_TAIL, 32'h7000_0000 + i, '0);
    send(CMD_INS_HEAD, '1, '0);
    send(CMD_INS_TAIL, '1, '0);
    send(CMD_INS_AFTER, '1, 32'h7000_0000);
    send(CMD_PREFIX_SUM, 32'h7000_001f, '0);
    send(CMD_SEARCH, 32'h7000_001f, '0);
    drain();

    random_phase(80, 0);
    drain();
    repeat (100) @(posedge clk);
    random_phase(80, 77);
    random_phase(80, 31);
    random_phase(80, 0);

    drain();
    repeat (100) @(posedge clk);
    if (sb.pending.size() == 0 && sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// File: files.f
src/lle_pkg.sv
src/lle_ram.sv
src/linked_list_engine.sv
tb/sv/tb_top.sv
